// File: sv/e2e22_pkg.sv
package e2e22_pkg;

    // Message size limit and derived compare width
    localparam int MAX_MESSAGE_BYTES = 4096;
    localparam int CMP_W             = 14;

    // Field widths
    localparam int OFFSET_W  = 12;
    localparam int LENGTH_W  = 13;
    localparam int CTR_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int IDS_W     = 64;
    localparam int CFG_IDX_W = 3;

    // CRC-8, polynomial 0x2F
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_XOR  = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h2F;
    localparam logic [CTR_W-1:0] CTR_RESET = 4'hF;

    // Check status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OKSOMELOST = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPEATED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WRONGSEQ   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ERROR      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONEWDATA  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRC_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDS_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDS_HIGH   = 3'd4;

    // Kind of a finished message record
    localparam logic [1:0] K_NODATA = 2'd0;
    localparam logic [1:0] K_LENERR = 2'd1;
    localparam logic [1:0] K_CHECK  = 2'd2;

    // Record queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       crc;
        logic [7:0]       cap_crc;
        logic [CTR_W-1:0] cap_ctr;
    } t_msg_rec;

    // One byte through the CRC-8, MSB first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: sv/e2e22_if.sv
interface e2e22_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       no_data;

    modport source (output valid, output data_byte, output last_byte, output no_data,
                    input ready);
    modport sink (input valid, input data_byte, input last_byte, input no_data,
                  output ready);
endinterface

interface e2e22_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] check_status;
    logic       input_error;
    logic [3:0] received_counter;
    logic [7:0] computed_crc;

    modport source (output valid, output check_status, output input_error,
                    output received_counter, output computed_crc, input ready);
    modport sink (input valid, input check_status, input input_error,
                  input received_counter, input computed_crc, output ready);
endinterface

// File: sv/e2e22_front.sv
module e2e22_front #(
    parameter int MAX_MESSAGE_BYTES = e2e22_pkg::MAX_MESSAGE_BYTES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    e2e22_in_if.sink                           i_in,
    input  logic [e2e22_pkg::OFFSET_W-1:0]     i_crc_offset,
    input  logic [e2e22_pkg::LENGTH_W-1:0]     i_msg_length,
    input  logic                               i_q_full,
    output logic                               o_push,
    output e2e22_pkg::t_msg_rec                o_rec
);

    localparam int CW = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_MESSAGE_BYTES);

    logic [CW-1:0]                  r_count, n_count;
    logic [7:0]                     r_crc, n_crc;
    logic [7:0]                     r_cap_crc, n_cap_crc;
    logic [e2e22_pkg::CTR_W-1:0]    r_cap_ctr, n_cap_ctr;

    logic                           accept;
    logic                           in_range;
    logic [e2e22_pkg::CMP_W-1:0]    pos;
    logic [e2e22_pkg::CMP_W-1:0]    off;
    logic [e2e22_pkg::CMP_W-1:0]    len;
    logic                           len_bad;

    // Take a word whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    assign in_range = (r_count != MaxCount);
    assign pos      = e2e22_pkg::CMP_W'(r_count);
    assign off      = e2e22_pkg::CMP_W'(i_crc_offset);
    assign len      = pos + e2e22_pkg::CMP_W'(1);
    assign len_bad  = !in_range || (len != e2e22_pkg::CMP_W'(i_msg_length)) ||
                      (len < off + e2e22_pkg::CMP_W'(2));

    // Accumulate the message and emit a record at its end or on a no-data word
    always_comb begin
        n_count   = r_count;
        n_crc     = r_crc;
        n_cap_crc = r_cap_crc;
        n_cap_ctr = r_cap_ctr;
        o_push    = 1'b0;
        o_rec     = '0;
        if (accept) begin
            if (i_in.no_data) begin
                o_push     = 1'b1;
                o_rec.kind = e2e22_pkg::K_NODATA;
                n_count    = '0;
                n_crc      = e2e22_pkg::CRC_INIT;
                n_cap_crc  = '0;
                n_cap_ctr  = '0;
            end else begin
                if (in_range) begin
                    if (pos == off) begin
                        n_cap_crc = i_in.data_byte;
                    end else begin
                        n_crc = e2e22_pkg::crc8_feed(r_crc, i_in.data_byte);
                        if (pos == off + e2e22_pkg::CMP_W'(1)) begin
                            n_cap_ctr = i_in.data_byte[e2e22_pkg::CTR_W-1:0];
                        end
                    end
                    n_count = r_count + CW'(1);
                end
                if (i_in.last_byte) begin
                    o_push        = 1'b1;
                    o_rec.kind    = len_bad ? e2e22_pkg::K_LENERR : e2e22_pkg::K_CHECK;
                    o_rec.crc     = n_crc;
                    o_rec.cap_crc = n_cap_crc;
                    o_rec.cap_ctr = n_cap_ctr;
                    n_count       = '0;
                    n_crc         = e2e22_pkg::CRC_INIT;
                    n_cap_crc     = '0;
                    n_cap_ctr     = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_crc     <= e2e22_pkg::CRC_INIT;
            r_cap_crc <= '0;
            r_cap_ctr <= '0;
        end else begin
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_cap_crc <= n_cap_crc;
            r_cap_ctr <= n_cap_ctr;
        end
    end

endmodule

// File: sv/e2e22_queue.sv
module e2e22_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  e2e22_pkg::t_msg_rec i_rec,
    output logic                o_full,
    output logic                o_valid,
    output e2e22_pkg::t_msg_rec o_rec,
    input  logic                i_pop
);

    e2e22_pkg::t_msg_rec                r_mem [e2e22_pkg::Q_DEPTH];
    logic [e2e22_pkg::Q_PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [e2e22_pkg::Q_PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [e2e22_pkg::Q_CNT_W-1:0]      r_count, n_count;
    logic                               pop;

    assign o_full  = (r_count == e2e22_pkg::Q_CNT_W'(e2e22_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == e2e22_pkg::Q_PTR_W'(e2e22_pkg::Q_DEPTH - 1)) ?
                       '0 : r_wr_ptr + e2e22_pkg::Q_PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == e2e22_pkg::Q_PTR_W'(e2e22_pkg::Q_DEPTH - 1)) ?
                       '0 : r_rd_ptr + e2e22_pkg::Q_PTR_W'(1);
        end
        if (i_push && !pop) begin
            n_count = r_count + e2e22_pkg::Q_CNT_W'(1);
        end else if (pop && !i_push) begin
            n_count = r_count - e2e22_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed record
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= e2e22_pkg::Q_CNT_W'(e2e22_pkg::Q_DEPTH))
        else $error("queue occupancy above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> (r_count == $past(r_count) + e2e22_pkg::Q_CNT_W'(1)))
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push) |=> (r_count == $past(r_count) - e2e22_pkg::Q_CNT_W'(1)))
        else $error("queue count missed a pop");

endmodule

// File: sv/e2e22_back.sv
module e2e22_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_rec_valid,
    input  e2e22_pkg::t_msg_rec                i_rec,
    output logic                               o_pop,
    input  logic [e2e22_pkg::CTR_W-1:0]        i_max_delta,
    input  logic [e2e22_pkg::IDS_W-1:0]        i_ids_low,
    input  logic [e2e22_pkg::IDS_W-1:0]        i_ids_high,
    e2e22_out_if.source                        o_out
);

    logic [e2e22_pkg::CTR_W-1:0]       r_last_counter, n_last_counter;
    logic [e2e22_pkg::STATUS_W-1:0]    r_last_status, n_last_status;
    logic                              r_out_valid;
    logic [e2e22_pkg::STATUS_W-1:0]    r_out_status, n_out_status;
    logic                              r_out_input_error, n_out_input_error;
    logic [e2e22_pkg::CTR_W-1:0]       r_out_counter, n_out_counter;
    logic [7:0]                        r_out_crc, n_out_crc;

    logic [e2e22_pkg::IDS_W-1:0]       id_word;
    logic [7:0]                        data_id;
    logic [7:0]                        final_crc;
    logic [e2e22_pkg::CTR_W-1:0]       delta;
    logic [e2e22_pkg::STATUS_W-1:0]    seq_status;

    // Pop when the output register is free or being drained
    assign o_pop = i_rec_valid && (!r_out_valid || o_out.ready);

    // Pick the data ID by counter and finish the CRC
    assign id_word   = i_rec.cap_ctr[3] ? i_ids_high : i_ids_low;
    assign data_id   = id_word[{i_rec.cap_ctr[2:0], 3'b000} +: 8];
    assign final_crc = e2e22_pkg::crc8_feed(i_rec.crc, data_id) ^ e2e22_pkg::CRC_XOR;
    assign delta     = i_rec.cap_ctr - r_last_counter;

    // Judge the counter step
    always_comb begin
        if (delta > i_max_delta) begin
            seq_status = e2e22_pkg::ST_WRONGSEQ;
        end else if (delta == '0) begin
            seq_status = e2e22_pkg::ST_REPEATED;
        end else if (delta == e2e22_pkg::CTR_W'(1)) begin
            seq_status = e2e22_pkg::ST_OK;
        end else begin
            seq_status = e2e22_pkg::ST_OKSOMELOST;
        end
    end

    // Build the result word and update the stored state
    always_comb begin
        n_last_counter    = r_last_counter;
        n_last_status     = r_last_status;
        n_out_status      = r_last_status;
        n_out_input_error = 1'b0;
        n_out_counter     = '0;
        n_out_crc         = '0;
        unique case (i_rec.kind)
            e2e22_pkg::K_NODATA: begin
                n_last_status = e2e22_pkg::ST_NONEWDATA;
                n_out_status  = e2e22_pkg::ST_NONEWDATA;
            end
            e2e22_pkg::K_LENERR: begin
                n_out_status      = r_last_status;
                n_out_input_error = 1'b1;
            end
            e2e22_pkg::K_CHECK: begin
                n_out_counter = i_rec.cap_ctr;
                n_out_crc     = final_crc;
                if (final_crc == i_rec.cap_crc) begin
                    n_last_status  = seq_status;
                    n_last_counter = i_rec.cap_ctr;
                end else begin
                    n_last_status = e2e22_pkg::ST_ERROR;
                end
                n_out_status = n_last_status;
            end
            default: begin
                n_out_status = r_last_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_counter <= e2e22_pkg::CTR_RESET;
            r_last_status  <= e2e22_pkg::ST_ERROR;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_last_counter <= n_last_counter;
                r_last_status  <= n_last_status;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output payload on each pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_status      <= n_out_status;
            r_out_input_error <= n_out_input_error;
            r_out_counter     <= n_out_counter;
            r_out_crc         <= n_out_crc;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.check_status     = r_out_status;
    assign o_out.input_error      = r_out_input_error;
    assign o_out.received_counter = r_out_counter;
    assign o_out.computed_crc     = r_out_crc;

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped record gave no result");

    a_nodata_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_rec.kind == e2e22_pkg::K_NODATA) |=>
        (r_last_status == e2e22_pkg::ST_NONEWDATA && r_out_status == e2e22_pkg::ST_NONEWDATA))
        else $error("no-data record did not report no new data");

    a_lenerr_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_rec.kind == e2e22_pkg::K_LENERR) |=>
        ($stable(r_last_status) && $stable(r_last_counter) && r_out_input_error))
        else $error("length error changed stored state");

endmodule

// File: sv/e2e_profile22_check_unit.sv
// A result word passes through the record queue and then the output register.
// Throughput: one input word per cycle, sustained while results are taken.
// The CRC step per byte in the front and the final CRC and counter check in the back
// are combinational; a two-entry record queue sits between them.
// Reset (i_rst_n low, synchronous) restores the control registers, the stored
// counter (15) and status (crc error), and discards any partly received message.
module e2e_profile22_check_unit #(
    parameter int MAX_MESSAGE_BYTES = e2e22_pkg::MAX_MESSAGE_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    e2e22_in_if.sink                            i_in_ch,
    e2e22_out_if.source                         o_out_ch,
    input  logic                                i_cfg_we,
    input  logic [e2e22_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [e2e22_pkg::IDS_W-1:0]         i_cfg_data
);

    logic [e2e22_pkg::OFFSET_W-1:0]  r_crc_offset;
    logic [e2e22_pkg::LENGTH_W-1:0]  r_msg_length;
    logic [e2e22_pkg::CTR_W-1:0]     r_max_delta;
    logic [e2e22_pkg::IDS_W-1:0]     r_ids_low;
    logic [e2e22_pkg::IDS_W-1:0]     r_ids_high;

    logic                            push;
    e2e22_pkg::t_msg_rec             push_rec;
    logic                            q_full;
    logic                            q_valid;
    e2e22_pkg::t_msg_rec             q_rec;
    logic                            pop;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_offset <= '0;
            r_msg_length <= e2e22_pkg::LENGTH_W'(8);
            r_max_delta  <= e2e22_pkg::CTR_W'(1);
            r_ids_low    <= '0;
            r_ids_high   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                e2e22_pkg::REG_CRC_OFFSET: r_crc_offset <= i_cfg_data[e2e22_pkg::OFFSET_W-1:0];
                e2e22_pkg::REG_MSG_LENGTH: r_msg_length <= i_cfg_data[e2e22_pkg::LENGTH_W-1:0];
                e2e22_pkg::REG_MAX_DELTA:  r_max_delta  <= i_cfg_data[e2e22_pkg::CTR_W-1:0];
                e2e22_pkg::REG_IDS_LOW:    r_ids_low    <= i_cfg_data;
                e2e22_pkg::REG_IDS_HIGH:   r_ids_high   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    e2e22_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in_ch),
        .i_crc_offset (r_crc_offset),
        .i_msg_length (r_msg_length),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_rec        (push_rec)
    );

    e2e22_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .i_pop   (pop)
    );

    e2e22_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (q_valid),
        .i_rec       (q_rec),
        .o_pop       (pop),
        .i_max_delta (r_max_delta),
        .i_ids_low   (r_ids_low),
        .i_ids_high  (r_ids_high),
        .o_out       (o_out_ch)
    );

endmodule
